// ===== src/rlcm_pkg.sv =====
`timescale 1ns / 1ps

package rlcm_pkg;

  localparam int VALUE_WIDTH_DEF = 64;   // default datapath width
  localparam int VALUE_BITS      = 64;   // width of the value / lcm fields on the ports
  localparam int DAY_W           = 3;
  localparam int DAYS_PER_WEEK   = 7;
  localparam int OUT_DATA_W      = 72;   // lcm + day, padded to whole bytes

  // microprogram addresses
  typedef enum logic [4:0] {
    ST_WAIT, ST_CLASS, ST_CHK, ST_ZERO, ST_CLR, ST_FIRST, ST_GCD, ST_LOOP,
    ST_MOD, ST_MODW, ST_SWAP, ST_QUOT, ST_QUOTW, ST_MUL, ST_MULW, ST_MULCHK,
    ST_DAY, ST_DAYW, ST_EMIT, ST_DONE
  } step_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_TAKE, OP_ACC_ZERO, OP_ACC_V, OP_LOAD_AB, OP_DIV_AB, OP_SWAP,
    OP_DIV_Q, OP_MUL, OP_MUL_DONE, OP_MOD7_SUM, OP_MOD7_FIN, OP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOIN, C_START, C_OVF, C_NZ, C_BZERO, C_BUSY,
    C_HIOVF, C_OUTFULL
  } cond_t;

  typedef enum logic {ALU_DIV, ALU_MUL} alu_mode_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic list_start;
    logic ovf;
    logic nonzero;
    logic b_zero;
    logic alu_busy;
    logic prod_hi;
    logic out_full;
  } seq_stat_t;

  // control store: jump to target when cond holds, else step to next address
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    unique case (pc)
      ST_WAIT:   w = '{OP_TAKE,     C_NOIN,    ST_WAIT};
      ST_CLASS:  w = '{OP_NONE,     C_START,   ST_FIRST};
      ST_CHK:    w = '{OP_NONE,     C_OVF,     ST_EMIT};
      ST_ZERO:   w = '{OP_NONE,     C_NZ,      ST_GCD};
      ST_CLR:    w = '{OP_ACC_ZERO, C_ALWAYS,  ST_DAY};
      ST_FIRST:  w = '{OP_ACC_V,    C_ALWAYS,  ST_DAY};
      ST_GCD:    w = '{OP_LOAD_AB,  C_NEVER,   ST_WAIT};
      ST_LOOP:   w = '{OP_NONE,     C_BZERO,   ST_QUOT};
      ST_MOD:    w = '{OP_DIV_AB,   C_NEVER,   ST_WAIT};
      ST_MODW:   w = '{OP_NONE,     C_BUSY,    ST_MODW};
      ST_SWAP:   w = '{OP_SWAP,     C_ALWAYS,  ST_LOOP};
      ST_QUOT:   w = '{OP_DIV_Q,    C_NEVER,   ST_WAIT};
      ST_QUOTW:  w = '{OP_NONE,     C_BUSY,    ST_QUOTW};
      ST_MUL:    w = '{OP_MUL,      C_NEVER,   ST_WAIT};
      ST_MULW:   w = '{OP_NONE,     C_BUSY,    ST_MULW};
      ST_MULCHK: w = '{OP_MUL_DONE, C_HIOVF,   ST_EMIT};
      ST_DAY:    w = '{OP_MOD7_SUM, C_NEVER,   ST_WAIT};
      ST_DAYW:   w = '{OP_MOD7_FIN, C_NEVER,   ST_WAIT};
      ST_EMIT:   w = '{OP_EMIT,     C_OUTFULL, ST_EMIT};
      ST_DONE:   w = '{OP_NONE,     C_ALWAYS,  ST_WAIT};
      default:   w = '{OP_NONE,     C_ALWAYS,  ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/rlcm_alu.sv =====
`timescale 1ns / 1ps

// Shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle.
// Divide: lo = quotient, hi = remainder. Multiply: {hi, lo} = product.
module rlcm_alu import rlcm_pkg::*; #(
  parameter int W = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  alu_mode_t    mode,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  output logic         busy,
  output logic [W-1:0] hi,
  output logic [W-1:0] lo
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  alu_mode_t        mode_r;
  logic [W-1:0]     hi_r, lo_r, opb_r;
  logic [W-1:0]     hi_nxt, lo_nxt;
  logic [W:0]       diff, sum;

  always_comb begin
    diff = {hi_r, lo_r[W-1]} - {1'b0, opb_r};
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, opb_r} : '0);
    if (mode_r == ALU_DIV) begin
      hi_nxt = diff[W] ? {hi_r[W-2:0], lo_r[W-1]} : diff[W-1:0];
      lo_nxt = {lo_r[W-2:0], ~diff[W]};
    end else begin
      hi_nxt = sum[W:1];
      lo_nxt = {sum[0], lo_r[W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r   <= '0;
      lo_r   <= opa;
      opb_r  <= opb;
      mode_r <= mode;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign busy = busy_r;
  assign hi   = hi_r;
  assign lo   = lo_r;

endmodule

// ===== src/rlcm_seq.sv =====
`timescale 1ns / 1ps

// Step counter over the control store with conditional jumps.
module rlcm_seq import rlcm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output uword_t    uw
);

  step_t pc_r, pc_nxt;
  logic  jump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw = ucode(pc_r);
    unique case (uw.cond)
      C_NEVER:   jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_NOIN:    jump = ~stat.in_valid;
      C_START:   jump = stat.list_start;
      C_OVF:     jump = stat.ovf;
      C_NZ:      jump = stat.nonzero;
      C_BZERO:   jump = stat.b_zero;
      C_BUSY:    jump = stat.alu_busy;
      C_HIOVF:   jump = stat.prod_hi;
      C_OUTFULL: jump = stat.out_full;
      default:   jump = 1'b1;
    endcase
    pc_nxt = jump ? uw.target : step_t'(5'(pc_r) + 5'd1);
  end

endmodule

// ===== src/running_lcm_day_offset.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Word                                       Accepted when
// in_      in   tdata[63:0] value, tlast = last            in_tvalid & in_tready
// out_     out  tdata[63:0] lcm, [66:64] day; tuser[0] ovf; out_tvalid & out_tready
//               tlast = list_end
// cfg_     in   cfg_data[2:0] start_day                    cfg_valid & cfg_ready
//
// One word at a time: in_tready is high only in the wait step. A word on a list
// that has overflowed goes straight to emit, a zero operand clears the lcm and the
// first word of a list is taken as the lcm. Otherwise Euclid remainder steps give
// the gcd; each remainder, the lcm divide and the multiply run on one shared
// bit-serial unit. Day mod 7 is folded by a sum step and a finish step, no divider.
// Reset (rst_n low at a clock edge): list restarts, start_day = 0, output empty.
// The output register lets the next word in while a result waits on out_tready;
// the next result then holds in the emit step until the register frees up.
module running_lcm_day_offset import rlcm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_BITS-1:0] in_tdata,   // [63:0] value
  input  logic                  in_tlast,   // last
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [63:0] running_lcm, [66:64] day_index, pad
  output logic [0:0]            out_tuser,  // [0] overflow
  output logic                  out_tlast,  // list_end
  // start_day register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DAY_W-1:0]      cfg_data    // start_day
);

  localparam int W      = VALUE_WIDTH;
  localparam int PAD_W  = OUT_DATA_W - VALUE_BITS - DAY_W;
  localparam int FOLD_N = (W + 5) / 6;   // 6-bit chunks, 64 = 1 mod 7
  localparam int FOLD_W = 10;            // up to 11 chunks of 63

  uword_t    uw;
  seq_stat_t stat;

  // datapath registers
  logic [DAY_W-1:0] start_day_r;
  logic [W-1:0]     acc_r, v_r, ra_r, rb_r;
  logic             last_r, ovf_r, list_start_r;

  // output register
  logic             out_valid_r, out_ovf_r, out_last_r;
  logic [W-1:0]     out_lcm_r;
  logic [DAY_W-1:0] out_day_r;

  logic             take, out_full, emit;
  logic             alu_start, alu_busy;
  alu_mode_t        alu_mode;
  logic [W-1:0]     alu_a, alu_b, alu_hi, alu_lo;
  logic [DAY_W:0]   day_sum, day_fix;

  // mod 7 fold
  logic [6*FOLD_N-1:0] acc_pad;
  logic [FOLD_W-1:0]   fold_sum, fold_r;
  logic [4:0]          dig_sum;
  logic [3:0]          dig_fold;
  logic [DAY_W-1:0]    rem7, rem7_r;

  rlcm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  rlcm_alu #(.W(W)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .mode  (alu_mode),
    .opa   (alu_a),
    .opb   (alu_b),
    .busy  (alu_busy),
    .hi    (alu_hi),
    .lo    (alu_lo)
  );

  assign in_tready = (uw.op == OP_TAKE);
  assign take      = in_tready & in_tvalid;
  assign out_full  = out_valid_r & ~out_tready;
  assign emit      = (uw.op == OP_EMIT) & ~out_full;
  assign cfg_ready = 1'b1;

  assign stat = '{
    in_valid:   in_tvalid,
    list_start: list_start_r,
    ovf:        ovf_r,
    nonzero:    (acc_r != '0) && (v_r != '0),
    b_zero:     (rb_r == '0),
    alu_busy:   alu_busy,
    prod_hi:    (alu_hi != '0),
    out_full:   out_full
  };

  // operand steering for the shared unit
  always_comb begin
    alu_start = 1'b0;
    alu_mode  = ALU_DIV;
    alu_a     = ra_r;
    alu_b     = rb_r;
    case (uw.op)
      OP_DIV_AB: begin            // ra mod rb, one Euclid step
        alu_start = 1'b1;
      end
      OP_DIV_Q: begin             // acc / gcd
        alu_start = 1'b1;
        alu_a     = acc_r;
        alu_b     = ra_r;
      end
      OP_MUL: begin               // quotient still sits in lo
        alu_start = 1'b1;
        alu_mode  = ALU_MUL;
        alu_a     = alu_lo;
        alu_b     = v_r;
      end
      default: ;
    endcase
  end

  // acc mod 7: sum of 6-bit chunks, then 3-bit digits (8 = 1 mod 7), then one subtract
  always_comb begin
    acc_pad  = (6*FOLD_N)'(acc_r);
    fold_sum = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      fold_sum = fold_sum + FOLD_W'(acc_pad[6*i +: 6]);
    end
    dig_sum  = 5'(fold_r[2:0]) + 5'(fold_r[5:3]) + 5'(fold_r[8:6]) + 5'(fold_r[9]);
    dig_fold = 4'(dig_sum[4:3]) + 4'(dig_sum[2:0]);
    rem7     = (dig_fold >= 4'(DAYS_PER_WEEK)) ?
               DAY_W'(dig_fold - 4'(DAYS_PER_WEEK)) : dig_fold[DAY_W-1:0];
  end

  // remainder < 7 and start_day <= 7: one conditional subtract wraps the week
  always_comb begin
    day_sum = {1'b0, rem7_r} + {1'b0, start_day_r};
    day_fix = (day_sum >= (DAY_W+1)'(DAYS_PER_WEEK)) ?
              day_sum - (DAY_W+1)'(DAYS_PER_WEEK) : day_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_day_r  <= '0;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      list_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        start_day_r <= cfg_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (uw.op)
        OP_ACC_ZERO: acc_r <= '0;
        OP_ACC_V: begin
          acc_r <= v_r;
          ovf_r <= 1'b0;
        end
        OP_MUL_DONE: begin
          if (alu_hi != '0) begin
            ovf_r <= 1'b1;        // sticky; acc holds
          end else begin
            acc_r <= alu_lo;
          end
        end
        OP_EMIT: begin
          if (!out_full) begin
            list_start_r <= last_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      v_r    <= in_tdata[W-1:0];
      last_r <= in_tlast;
    end
    if (uw.op == OP_LOAD_AB) begin
      ra_r <= acc_r;
      rb_r <= v_r;
    end else if (uw.op == OP_SWAP) begin
      ra_r <= rb_r;
      rb_r <= alu_hi;
    end
    if (uw.op == OP_MOD7_SUM) begin
      fold_r <= fold_sum;
    end
    if (uw.op == OP_MOD7_FIN) begin
      rem7_r <= rem7;
    end
    if (emit) begin
      out_lcm_r  <= ovf_r ? '0 : acc_r;
      out_day_r  <= ovf_r ? '0 : day_fix[DAY_W-1:0];
      out_ovf_r  <= ovf_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_day_r, VALUE_BITS'(out_lcm_r)};
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_alu_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    alu_start |-> !alu_busy)
    else $error("shared unit restarted while busy");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !alu_busy)
    else $error("input taken while shared unit busy");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[VALUE_BITS+DAY_W-1:0] == '0))
    else $error("overflowed result carries nonzero lcm or day");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[VALUE_BITS+DAY_W-1:VALUE_BITS] != 3'd7))
    else $error("day index out of range");
`endif

endmodule
